// ----- hw/rtl/psjc_pkg.sv -----
// Shared types, constants and helper functions for the pan sweep / joystick controller.
// No dependencies; imported by pan_sweep_joystick_controller_unit.
package psjc_pkg;

  // Input word: one 1 ms tick of sensor and mode data
  typedef struct packed {
    logic [9:0]  distance;
    logic [15:0] joystick_level;
    logic        manual_mode;
    logic [11:0] current_angle;
  } in_word_t;

  // Result word: motor command and detection status
  typedef struct packed {
    logic [11:0] target_angle;
    logic        motor_enable;
    logic        detected;
    logic        detect_alert;
  } out_word_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DETECT_DISTANCE = 3'd0,
    CFG_SWEEP_HALF_MS   = 3'd1,
    CFG_LEFT_ANGLE      = 3'd2,
    CFG_RIGHT_ANGLE     = 3'd3,
    CFG_MIN_ANGLE       = 3'd4,
    CFG_MAX_ANGLE       = 3'd5
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  // Register reset values
  localparam logic [9:0]  RST_DETECT_DISTANCE = 10'd20;
  localparam logic [13:0] RST_SWEEP_HALF_MS   = 14'd7000;
  localparam logic [11:0] RST_LEFT_ANGLE      = 12'd1024;
  localparam logic [11:0] RST_RIGHT_ANGLE     = 12'd3072;
  localparam logic [11:0] RST_MIN_ANGLE       = 12'd20;
  localparam logic [11:0] RST_MAX_ANGLE       = 12'd4070;
  localparam logic [11:0] RST_TARGET          = 12'd2048;

  // Joystick thresholds
  localparam logic [15:0] JOY_TH_P4 = 16'd60000;
  localparam logic [15:0] JOY_TH_P3 = 16'd50000;
  localparam logic [15:0] JOY_TH_P2 = 16'd40000;
  localparam logic [15:0] JOY_TH_P1 = 16'd30000;
  localparam logic [15:0] JOY_TH_Z  = 16'd18000;
  localparam logic [15:0] JOY_TH_M1 = 16'd15000;
  localparam logic [15:0] JOY_TH_M2 = 16'd10000;
  localparam logic [15:0] JOY_TH_M3 = 16'd5000;

  // Map a joystick level to a signed step of -4 to +4
  function automatic logic signed [3:0] joy_step(input logic [15:0] lvl);
    logic signed [3:0] d;
    if (lvl > JOY_TH_P4)      d = 4'sd4;
    else if (lvl > JOY_TH_P3) d = 4'sd3;
    else if (lvl > JOY_TH_P2) d = 4'sd2;
    else if (lvl > JOY_TH_P1) d = 4'sd1;
    else if (lvl > JOY_TH_Z)  d = 4'sd0;
    else if (lvl > JOY_TH_M1) d = -4'sd1;
    else if (lvl > JOY_TH_M2) d = -4'sd2;
    else if (lvl > JOY_TH_M3) d = -4'sd3;
    else                      d = -4'sd4;
    return d;
  endfunction

endpackage

// ----- hw/rtl/pan_sweep_joystick_controller_unit.sv -----
// Pan sweep / joystick controller: top level with input register, tick logic and result register.
// Depends on psjc_pkg for word types, register indexes, reset values and the joystick map.
//
//   channel | ports                               | direction | word
//   --------+-------------------------------------+-----------+-----------
//   input   | in_valid, in_stall, in_data         | in        | in_word_t
//   result  | out_valid, out_stall, out_data      | out       | out_word_t
//   config  | cfg_we, cfg_index, cfg_wdata        | in        | 14 bit
//
// One word is taken per cycle while the result side does not stall; its result is offered
// from the result register, after the input register and the tick logic between them.
// Controller state advances when a word moves from the input to the result register.
// rst_n is synchronous: it empties both registers and restores state and config.
// A stalled result holds; the input register takes one more word, then stalls.
module pan_sweep_joystick_controller_unit
  import psjc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [9:0]  detect_distance_r;
  logic [13:0] sweep_half_ms_r;
  logic [11:0] left_angle_r;
  logic [11:0] right_angle_r;
  logic [11:0] min_angle_r;
  logic [11:0] max_angle_r;

  // Controller state
  logic [15:0] ms_count_r, ms_count_nxt;
  logic        sweep_running_r, sweep_running_nxt;
  logic [11:0] target_r, target_nxt;
  logic        drive_en_r, drive_en_nxt;
  logic        prev_detected_r;
  logic        prev_rotating_r;

  // Pipeline registers
  in_word_t    in_q_r;
  logic        in_q_valid_r;
  out_word_t   out_q_r;
  logic        out_q_valid_r;

  logic        advance;
  logic        load;

  // Tick logic intermediates
  logic signed [3:0]  joy_d;
  logic signed [13:0] step_sum;
  logic [11:0]        clamped;
  logic               det;
  logic               alert;
  logic               rotating;
  logic [14:0]        sweep_full;

  // Handshake: result register frees when empty or taken
  assign advance   = !out_q_valid_r || !out_stall;
  assign load      = in_q_valid_r && advance;
  assign in_stall  = in_q_valid_r && !advance;
  assign out_valid = out_q_valid_r;
  assign out_data  = out_q_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_distance_r <= RST_DETECT_DISTANCE;
      sweep_half_ms_r   <= RST_SWEEP_HALF_MS;
      left_angle_r      <= RST_LEFT_ANGLE;
      right_angle_r     <= RST_RIGHT_ANGLE;
      min_angle_r       <= RST_MIN_ANGLE;
      max_angle_r       <= RST_MAX_ANGLE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DETECT_DISTANCE: detect_distance_r <= cfg_wdata[9:0];
        CFG_SWEEP_HALF_MS:   sweep_half_ms_r   <= cfg_wdata;
        CFG_LEFT_ANGLE:      left_angle_r      <= cfg_wdata[11:0];
        CFG_RIGHT_ANGLE:     right_angle_r     <= cfg_wdata[11:0];
        CFG_MIN_ANGLE:       min_angle_r       <= cfg_wdata[11:0];
        CFG_MAX_ANGLE:       max_angle_r       <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Tick logic: timer, joystick step, clamp, detection, sweep and stop
  always_comb begin
    // advance the sweep timer
    ms_count_nxt = sweep_running_r ? (ms_count_r + 16'd1) : 16'd0;

    // joystick step in manual mode
    joy_d        = joy_step(in_q_r.joystick_level);
    drive_en_nxt = drive_en_r;
    step_sum     = $signed({2'b00, target_r});
    if (in_q_r.manual_mode) begin
      drive_en_nxt = 1'b1;
      step_sum     = $signed({2'b00, target_r}) + $signed({{10{joy_d[3]}}, joy_d});
    end

    // clamp, lower bound first
    if (step_sum <= $signed({2'b00, min_angle_r}))
      clamped = min_angle_r;
    else if (step_sum >= $signed({2'b00, max_angle_r}))
      clamped = max_angle_r;
    else
      clamped = step_sum[11:0];
    target_nxt = clamped;

    // detection and its rising edge
    det   = in_q_r.distance <= detect_distance_r;
    alert = det && !prev_detected_r;

    // auto sweep: left half, right half, then restart
    rotating          = !det && !in_q_r.manual_mode;
    sweep_full        = {sweep_half_ms_r, 1'b0};
    sweep_running_nxt = sweep_running_r;
    if (rotating) begin
      sweep_running_nxt = 1'b1;
      drive_en_nxt      = 1'b1;
      if (ms_count_nxt < {2'b00, sweep_half_ms_r})
        target_nxt = left_angle_r;
      else if (ms_count_nxt < {1'b0, sweep_full})
        target_nxt = right_angle_r;
      else
        sweep_running_nxt = 1'b0;
    end

    // rotation stopped: motor off, freeze at the reported angle
    if (prev_rotating_r && !rotating) begin
      drive_en_nxt = 1'b0;
      target_nxt   = in_q_r.current_angle;
    end
  end

  // Update controller state when a word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_count_r      <= 16'd0;
      sweep_running_r <= 1'b0;
      target_r        <= RST_TARGET;
      drive_en_r      <= 1'b1;
      prev_detected_r <= 1'b0;
      prev_rotating_r <= 1'b0;
    end else if (load) begin
      ms_count_r      <= ms_count_nxt;
      sweep_running_r <= sweep_running_nxt;
      target_r        <= target_nxt;
      drive_en_r      <= drive_en_nxt;
      prev_detected_r <= det;
      prev_rotating_r <= rotating;
    end
  end

  // Input register: refill whenever empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_r <= in_data;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_q_valid_r <= 1'b0;
    end else if (advance) begin
      out_q_valid_r <= in_q_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q_r.target_angle <= target_nxt;
      out_q_r.motor_enable <= drive_en_nxt;
      out_q_r.detected     <= det;
      out_q_r.detect_alert <= alert;
    end
  end

`ifndef SYNTH
  // State changes only when a word moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(ms_count_r) && $stable(target_r) && $stable(drive_en_r))
    else $error("controller state changed without a word moving on");

  // Detection history follows the last result produced
  a_prev_det: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> prev_detected_r == out_q_r.detected)
    else $error("detection history differs from last result");

  // An alert is only raised together with detection
  a_alert_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_q_valid_r && out_q_r.detect_alert |-> out_q_r.detected)
    else $error("alert without detection");

  // Timer restarts from zero once the sweep has stopped
  a_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load && !sweep_running_r |=> ms_count_r == 16'd0)
    else $error("sweep timer not cleared");

  // Input side stalls only with a full input register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_q_valid_r && out_q_valid_r)
    else $error("input stalled with room to take a word");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for pan_sweep_joystick_controller_unit: drives tick words, predicts
// each result word in a scoreboard class and compares it field by field.
// Depends on psjc_pkg for word types, register indexes and joystick thresholds.
`timescale 1ns / 1ps

module testbench;
  import psjc_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_WORDS  = 144;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [15:0] JOY_MARKS [8] = '{JOY_TH_P4, JOY_TH_P3, JOY_TH_P2, JOY_TH_P1,
                                            JOY_TH_Z, JOY_TH_M1, JOY_TH_M2, JOY_TH_M3};

  // Predict the controller tick by tick and hold the result words still to come
  class tick_scoreboard;
    logic [9:0]  detect_dist;
    logic [13:0] half_ms;
    logic [11:0] left_pos, right_pos, lo_bound, hi_bound;
    logic [15:0] ms_count;
    bit          sweeping;
    logic [11:0] target;
    bit          drive_on, was_detected, was_rotating;
    out_word_t   expected_words[$];
    int          errors, words_in, words_out, alerts, motor_stops, sweep_ends;

    function new();
      detect_dist  = RST_DETECT_DISTANCE;
      half_ms      = RST_SWEEP_HALF_MS;
      left_pos     = RST_LEFT_ANGLE;
      right_pos    = RST_RIGHT_ANGLE;
      lo_bound     = RST_MIN_ANGLE;
      hi_bound     = RST_MAX_ANGLE;
      ms_count     = '0;
      sweeping     = 1'b0;
      target       = RST_TARGET;
      drive_on     = 1'b1;
      was_detected = 1'b0;
      was_rotating = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_idx_t'(idx))
        CFG_DETECT_DISTANCE: detect_dist = data[9:0];
        CFG_SWEEP_HALF_MS:   half_ms     = data[13:0];
        CFG_LEFT_ANGLE:      left_pos    = data[11:0];
        CFG_RIGHT_ANGLE:     right_pos   = data[11:0];
        CFG_MIN_ANGLE:       lo_bound    = data[11:0];
        CFG_MAX_ANGLE:       hi_bound    = data[11:0];
        default: ;
      endcase
    endfunction

    function int joy_step_of(logic [15:0] lvl);
      if (lvl > JOY_TH_P4) return 4;
      if (lvl > JOY_TH_P3) return 3;
      if (lvl > JOY_TH_P2) return 2;
      if (lvl > JOY_TH_P1) return 1;
      if (lvl > JOY_TH_Z)  return 0;
      if (lvl > JOY_TH_M1) return -1;
      if (lvl > JOY_TH_M2) return -2;
      if (lvl > JOY_TH_M3) return -3;
      return -4;
    endfunction

    // Advance one tick and queue the result word it yields
    function void note_word(in_word_t w);
      int        t;
      bit        det, alert, rot;
      out_word_t e;
      words_in++;
      if (sweeping) ms_count = ms_count + 16'd1;
      else ms_count = '0;
      // joystick nudge, then clamp with the lower bound tested first
      t = int'(target);
      if (w.manual_mode) begin
        drive_on = 1'b1;
        t += joy_step_of(w.joystick_level);
      end
      if (t <= int'(lo_bound)) t = int'(lo_bound);
      else if (t >= int'(hi_bound)) t = int'(hi_bound);
      target = t[11:0];
      det = (w.distance <= detect_dist);
      alert = det && !was_detected;
      was_detected = det;
      // sweep left, then right, then restart the timer
      rot = !det && !w.manual_mode;
      if (rot) begin
        sweeping = 1'b1;
        drive_on = 1'b1;
        if (ms_count < half_ms) target = left_pos;
        else if (int'(ms_count) < 2 * int'(half_ms)) target = right_pos;
        else begin
          sweeping = 1'b0;
          sweep_ends++;
        end
      end
      // freeze at the reported angle when rotation stops
      if (was_rotating && !rot) begin
        drive_on = 1'b0;
        target = w.current_angle;
        motor_stops++;
      end
      was_rotating = rot;
      if (alert) alerts++;
      e.target_angle = target;
      e.motor_enable = drive_on;
      e.detected     = det;
      e.detect_alert = alert;
      expected_words.push_back(e);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      words_out++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
      end else begin
        e = expected_words.pop_front();
        compare_field("target_angle", e.target_angle, got.target_angle);
        compare_field("motor_enable", e.motor_enable, got.motor_enable);
        compare_field("detected", e.detected, got.detected);
        compare_field("detect_alert", e.detect_alert, got.detect_alert);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tick_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int seg_left      = 0;
  bit seg_manual    = 1'b0;
  int seg_near_pct  = 5;

  pan_sweep_joystick_controller_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check accepted result words and stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic in_word_t make_word(logic [9:0] range_cm, logic [15:0] lvl, logic manual,
                                         logic [11:0] cur);
    in_word_t w;
    w.distance       = range_cm;
    w.joystick_level = lvl;
    w.manual_mode    = manual;
    w.current_angle  = cur;
    return w;
  endfunction

  // Runs of one mode with random content; a few words are pure noise
  function automatic in_word_t random_word();
    in_word_t    w;
    logic [63:0] noise;
    int          dd;
    if (seg_left == 0) begin
      seg_left     = $urandom_range(40, 1);
      seg_manual   = 1'($urandom_range(1, 0));
      seg_near_pct = ($urandom_range(3, 0) == 0) ? 70 : 5;
    end
    seg_left--;
    dd = int'(sb.detect_dist);
    if ($urandom_range(99, 0) < seg_near_pct || dd == 1023)
      w.distance = 10'($urandom_range(dd, 0));
    else
      w.distance = 10'($urandom_range(1023, dd + 1));
    if ($urandom_range(1, 0) != 0)
      w.joystick_level = JOY_MARKS[$urandom_range(7, 0)] + 16'($urandom_range(2, 0));
    else
      w.joystick_level = 16'($urandom);
    w.manual_mode = seg_manual;
    case ($urandom_range(3, 0))
      0:       w.current_angle = '0;
      1:       w.current_angle = '1;
      default: w.current_angle = 12'($urandom);
    endcase
    if ($urandom_range(9, 0) == 0) begin
      noise = {$urandom, $urandom};
      w = noise[$bits(in_word_t)-1:0];
    end
    return w;
  endfunction

  // Present one word, idling first at random, and hold it until taken
  task automatic send_word(in_word_t w);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register settings per phase, extremes first
  task automatic configure_phase(int p);
    case (p)
      0: ;
      1: begin
        write_reg(CFG_DETECT_DISTANCE, 14'd0);
        write_reg(CFG_SWEEP_HALF_MS, 14'd1);
        write_reg(CFG_LEFT_ANGLE, 14'd0);
        write_reg(CFG_RIGHT_ANGLE, 14'd4095);
        write_reg(CFG_MIN_ANGLE, 14'd0);
        write_reg(CFG_MAX_ANGLE, 14'd4095);
      end
      2: begin
        write_reg(CFG_DETECT_DISTANCE, 14'd1023);
        write_reg(CFG_SWEEP_HALF_MS, 14'd16383);
        write_reg(CFG_LEFT_ANGLE, 14'd4095);
        write_reg(CFG_RIGHT_ANGLE, 14'd0);
        write_reg(CFG_MIN_ANGLE, 14'd4095);
        write_reg(CFG_MAX_ANGLE, 14'd0);
      end
      3: begin
        write_reg(CFG_DETECT_DISTANCE, 14'd300);
        write_reg(CFG_SWEEP_HALF_MS, 14'd0);
        write_reg(CFG_LEFT_ANGLE, 14'd5);
        write_reg(CFG_RIGHT_ANGLE, 14'd4090);
        write_reg(CFG_MIN_ANGLE, 14'd100);
        write_reg(CFG_MAX_ANGLE, 14'd200);
      end
      5: begin
        // raw 14-bit data everywhere, spare indexes included
        for (int i = 0; i < 8; i++) write_reg(i[CFG_IDX_W-1:0], 14'($urandom));
        write_reg(CFG_SPARE_LO, 14'($urandom));
        write_reg(CFG_SPARE_HI, 14'($urandom));
        write_reg(CFG_SWEEP_HALF_MS, 14'($urandom_range(20, 1)));
      end
      6: begin
        write_reg(CFG_DETECT_DISTANCE, 14'd512);
        write_reg(CFG_SWEEP_HALF_MS, 14'd3);
        write_reg(CFG_LEFT_ANGLE, 14'd10);
        write_reg(CFG_RIGHT_ANGLE, 14'd4000);
        write_reg(CFG_MIN_ANGLE, 14'd2000);
        write_reg(CFG_MAX_ANGLE, 14'd2000);
      end
      default: begin
        write_reg(CFG_DETECT_DISTANCE, 14'($urandom_range(1023, 0)));
        write_reg(CFG_SWEEP_HALF_MS, 14'($urandom_range(12, 2)));
        write_reg(CFG_LEFT_ANGLE, 14'($urandom_range(4095, 0)));
        write_reg(CFG_RIGHT_ANGLE, 14'($urandom_range(4095, 0)));
        write_reg(CFG_MIN_ANGLE, 14'($urandom_range(2000, 0)));
        write_reg(CFG_MAX_ANGLE, 14'($urandom_range(4095, 2100)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sweep start, stop and freeze, every joystick band edge, detection edges
    send_word(make_word(10'd1023, 16'd19000, 1'b0, 12'd0));
    send_word(make_word(10'd1023, 16'hFFFF, 1'b1, 12'hFFF));
    for (int i = 0; i < 8; i++) begin
      send_word(make_word((i % 3 == 0) ? 10'd21 : ((i % 3 == 1) ? 10'd20 : 10'd0),
                          JOY_MARKS[i] + 16'd1, 1'b1, 12'd0));
      send_word(make_word((i % 2 == 0) ? 10'd1023 : 10'd20, JOY_MARKS[i], 1'b1, 12'hFFF));
    end
    send_word(make_word(10'd0, 16'd0, 1'b1, 12'd0));
    send_word(make_word(10'd20, 16'hFFFF, 1'b0, 12'd0));
    send_word(make_word(10'd1023, 16'd0, 1'b0, 12'd2222));
    send_word(make_word(10'd1023, 16'd0, 1'b0, 12'd0));
    send_word(make_word(10'd5, 16'd0, 1'b0, 12'd0));
    send_word(make_word(10'd1023, 16'd0, 1'b1, 12'd0));
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each with its own settings; the idling and stall pattern repeats every four phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 60; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      configure_phase(p);
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
      in_valid <= 1'b0;
      wait_drained();
    end

    $display("Covered %0d tick words over %0d phases; %0d result words checked.",
             sb.words_in, NUM_PHASES + 1, sb.words_out);
    $display("Saw %0d detection alerts, %0d motor stops and %0d sweep restarts.",
             sb.alerts, sb.motor_stops, sb.sweep_ends);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- pan_sweep_joystick_controller_unit.f -----
hw/rtl/psjc_pkg.sv
hw/rtl/pan_sweep_joystick_controller_unit.sv
tb/testbench.sv
